// ----- rtl/core/amx_pkg.sv -----
package amx_pkg;

    localparam int WORD_W = 12;
    localparam int CHAR_W = 8;
    localparam int MODE_W = 6;

    typedef enum logic [MODE_W-1:0] {
        OP_AND = 6'd0,  OP_TAD = 6'd1,  OP_ISZ = 6'd2,  OP_DCA = 6'd3,
        OP_JMS = 6'd4,  OP_JMP = 6'd5,  OP_KCF = 6'd6,  OP_KSF = 6'd7,
        OP_KCC = 6'd8,  OP_KRS = 6'd9,  OP_KRB = 6'd10, OP_TFL = 6'd11,
        OP_TSF = 6'd12, OP_TCF = 6'd13, OP_TPC = 6'd14, OP_TLS = 6'd15,
        OP_CLA = 6'd16, OP_CLL = 6'd17, OP_CMA = 6'd18, OP_CML = 6'd19,
        OP_IAC = 6'd20, OP_RAR = 6'd21, OP_RTR = 6'd22, OP_RAL = 6'd23,
        OP_RTL = 6'd24, OP_SMA = 6'd25, OP_SZA = 6'd26, OP_SNL = 6'd27,
        OP_SPA = 6'd28, OP_SNA = 6'd29, OP_SZL = 6'd30, OP_SKP = 6'd31,
        OP_OSR = 6'd32, OP_HLT = 6'd33, OP_NOP = 6'd63
    } op_t;

    typedef enum logic { CFG_SWITCH = 1'b0, CFG_START = 1'b1 } cfg_idx_t;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] mdata;
        logic              kflag;
        logic [CHAR_W-1:0] kchar;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    typedef struct packed {
        logic [WORD_W-1:0] acc;
        logic              lnk;
        logic [WORD_W-1:0] pc;
        logic              we;
        logic [WORD_W-1:0] wd;
        logic              pv;
        logic [CHAR_W-1:0] pchar;
        logic              ckf;
        logic              skip;
        logic              hlt;
    } res_t;

    typedef struct packed {
        logic push;
    } qctl_t;

endpackage

// ----- rtl/core/amx_front.sv -----
module amx_front (
    input  logic                       in_valid,
    input  logic [39:0]                in_data,
    input  logic                       q_full,
    output logic                       in_ready,
    output amx_pkg::qctl_t             qctl,
    output amx_pkg::cmd_t              cmd
);
    import amx_pkg::*;

    logic [MODE_W-1:0] mode;

    assign mode      = in_data[MODE_W-1:0];
    assign in_ready  = !q_full;
    assign qctl.push = in_valid && in_ready;

    // unused mode codes fold to a no-op
    always_comb
    begin
        if (mode <= MODE_W'(OP_HLT))
            cmd.op = op_t'(mode);
        else
            cmd.op = OP_NOP;
        cmd.addr  = in_data[17:6];
        cmd.mdata = in_data[29:18];
        cmd.kflag = in_data[30];
        cmd.kchar = in_data[38:31];
    end
endmodule

// ----- rtl/core/amx_queue.sv -----
module amx_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  amx_pkg::qctl_t qctl,
    input  amx_pkg::cmd_t  wr_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output amx_pkg::cmd_t  rd_cmd
);
    import amx_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign rd_cmd    = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg + 1'(qctl.push);
        rp_next  = rp_reg + 1'(pop);
        cnt_next = cnt_reg + 2'(qctl.push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (qctl.push)
            mem_reg[wp_reg] <= wr_cmd;
    end
endmodule

// ----- rtl/core/amx_back.sv -----
module amx_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [amx_pkg::WORD_W-1:0]   sw_reg,
    input  logic [amx_pkg::WORD_W-1:0]   start_pc,
    input  logic                         q_valid,
    input  amx_pkg::cmd_t                cmd,
    input  logic                         out_ready,
    output logic                         pop,
    output logic                         out_valid,
    output amx_pkg::res_t                res
);
    import amx_pkg::*;

    logic [WORD_W-1:0] acc_reg, acc_next, pc_reg, pc_next, mb_reg, mb_next;
    logic              lnk_reg, lnk_next, pf_reg, pf_next;
    logic              ov_reg;
    res_t              res_reg, r;
    logic [WORD_W:0]   sum;
    logic [WORD_W-1:0] pc_inc, isz_val, kc;

    assign pop       = q_valid && (!ov_reg || out_ready);
    assign out_valid = ov_reg;
    assign res       = res_reg;

    always_comb
    begin
        sum      = {1'b0, acc_reg} + {1'b0, cmd.mdata};
        pc_inc   = pc_reg + 1'b1;
        isz_val  = cmd.mdata + 1'b1;
        kc       = {cmd.kchar, {(WORD_W-CHAR_W){1'b0}}};
        acc_next = acc_reg;
        lnk_next = lnk_reg;
        pc_next  = pc_reg;
        mb_next  = mb_reg;
        pf_next  = pf_reg;
        r        = '0;
        case (cmd.op)
            OP_AND: begin mb_next = cmd.mdata; acc_next = acc_reg & cmd.mdata; end
            OP_TAD:
            begin
                mb_next  = cmd.mdata;
                acc_next = sum[WORD_W-1:0];
                lnk_next = lnk_reg ^ sum[WORD_W];
            end
            OP_ISZ:
            begin
                mb_next = isz_val; r.we = 1'b1; r.wd = isz_val;
                if (isz_val == '0)
                    pc_next = pc_inc;
            end
            OP_DCA: begin mb_next = acc_reg; r.we = 1'b1; r.wd = acc_reg; acc_next = '0; end
            OP_JMS:
            begin
                mb_next = pc_reg; r.we = 1'b1; r.wd = pc_reg;
                pc_next = cmd.addr + 1'b1;
            end
            OP_JMP: pc_next = cmd.addr;
            OP_KCF: r.ckf = 1'b1;
            OP_KSF: if (cmd.kflag) pc_next = pc_inc;
            OP_KCC: begin acc_next = '0; r.ckf = 1'b1; end
            OP_KRS: acc_next = acc_reg | kc;
            OP_KRB: begin acc_next = kc; r.ckf = 1'b1; end
            OP_TFL: pf_next = 1'b1;
            OP_TSF: if (pf_reg) pc_next = pc_inc;
            OP_TCF: pf_next = 1'b0;
            OP_TPC: begin r.pv = 1'b1; r.pchar = acc_reg[WORD_W-1 -: CHAR_W]; end
            OP_TLS:
            begin
                pf_next = 1'b0; r.pv = 1'b1; r.pchar = acc_reg[WORD_W-1 -: CHAR_W];
            end
            OP_CLA: acc_next = '0;
            OP_CLL: lnk_next = 1'b0;
            OP_CMA: acc_next = ~acc_reg;
            OP_CML: lnk_next = ~lnk_reg;
            OP_IAC: acc_next = acc_reg + 1'b1;
            OP_RAR: {acc_next, lnk_next} = {lnk_reg, acc_reg};
            OP_RTR:
            begin
                acc_next = {acc_reg[0], lnk_reg, acc_reg[WORD_W-1:2]};
                lnk_next = acc_reg[1];
            end
            OP_RAL: {lnk_next, acc_next} = {acc_reg, lnk_reg};
            OP_RTL:
            begin
                acc_next = {acc_reg[WORD_W-3:0], lnk_reg, acc_reg[WORD_W-1]};
                lnk_next = acc_reg[WORD_W-2];
            end
            OP_SMA: r.skip = acc_reg[WORD_W-1];
            OP_SZA: r.skip = (acc_reg == '0);
            OP_SNL: r.skip = lnk_reg;
            OP_SPA: r.skip = !acc_reg[WORD_W-1];
            OP_SNA: r.skip = (acc_reg != '0);
            OP_SZL: r.skip = !lnk_reg;
            OP_SKP: pc_next = pc_inc;
            OP_OSR: acc_next = acc_reg | sw_reg;
            OP_HLT: r.hlt = 1'b1;
            default: ;
        endcase
        r.acc = acc_next;
        r.lnk = lnk_next;
        r.pc  = pc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            lnk_reg <= 1'b0;
            pc_reg  <= start_pc;
            mb_reg  <= '0;
            pf_reg  <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                acc_reg <= acc_next;
                lnk_reg <= lnk_next;
                pc_reg  <= pc_next;
                mb_reg  <= mb_next;
                pf_reg  <= pf_next;
                ov_reg  <= 1'b1;
            end
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            res_reg <= r;
    end
endmodule

// ----- rtl/core/accumulator_machine_execute_unit.sv -----
// An accepted word passes the queue and the result register to m_axis.
// Throughput: one word per cycle while m_axis_tready is high; a two-entry
// queue separates input from execute so each side stalls on its own.
// Reset (rst_n, async low): AC, link, memory buffer, printer flag cleared,
// PC loaded from the start address register, switch register cleared.
module accumulator_machine_execute_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // mode[5:0], operand_address[17:6], memory_data[29:18], key_flag[30],
    // key_char[38:31], zero pad[39]
    input  logic [39:0]                 s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // accumulator_out[11:0], link_out[12], pc_out[24:13], write_enable[25],
    // write_data[37:26], print_valid[38], print_char[46:39],
    // clear_key_flag[47], skip_test[48], halt[49], zero pad[55:50]
    output logic [55:0]                 m_axis_tdata,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [amx_pkg::WORD_W-1:0]  cfg_data
);
    import amx_pkg::*;

    logic [WORD_W-1:0] sw_reg, start_reg;
    qctl_t qctl;
    cmd_t  f_cmd, q_cmd;
    logic  q_full, q_ne, pop;
    res_t  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg    <= '0;
            start_reg <= WORD_W'(128);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SWITCH: sw_reg    <= WORD_W'(cfg_data);
                CFG_START:  start_reg <= WORD_W'(cfg_data);
                default: ;
            endcase
        end
    end

    amx_front u_front (
        .in_valid(s_axis_tvalid), .in_data(s_axis_tdata),
        .q_full(q_full), .in_ready(s_axis_tready), .qctl(qctl), .cmd(f_cmd)
    );

    amx_queue u_queue (
        .clk(clk), .rst_n(rst_n), .qctl(qctl), .wr_cmd(f_cmd), .pop(pop),
        .full(q_full), .not_empty(q_ne), .rd_cmd(q_cmd)
    );

    amx_back u_back (
        .clk(clk), .rst_n(rst_n), .sw_reg(sw_reg), .start_pc(start_reg),
        .q_valid(q_ne), .cmd(q_cmd), .out_ready(m_axis_tready), .pop(pop),
        .out_valid(m_axis_tvalid), .res(res)
    );

    assign m_axis_tdata = {6'd0, res.hlt, res.skip, res.ckf, res.pchar, res.pv,
                           res.wd, res.we, res.pc, res.lnk, res.acc};

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_ne) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !s_axis_tready) else $error("ready while queue full");
    a_pop_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> m_axis_tvalid) else $error("executed word not presented");
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import amx_pkg::*;

    localparam int   IDLE_LIMIT = 5000;
    localparam int   HOLD_LEN   = 300;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] mdata;
        logic              kflag;
        logic [CHAR_W-1:0] kchar;
        bit                known;
        res_t              want;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [39:0]         s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [55:0]         m_axis_tdata;
    logic                cfg_we;
    logic                cfg_index;
    logic [WORD_W-1:0]   cfg_data;

    // machine state as the execute unit should hold it
    logic [WORD_W-1:0] ac, pc, mbuf, sw_reg;
    logic              lnk, pflag;

    res_t  pending_words[$];
    row_t  plan[$];
    int    errors;
    int    idle_cycles;
    bit    calm;
    bit    hold_req;
    int    hold_left;

    accumulator_machine_execute_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic res_t execute(input logic [MODE_W-1:0] mode,
                                     input logic [WORD_W-1:0] addr,
                                     input logic [WORD_W-1:0] mdata,
                                     input logic kflag,
                                     input logic [CHAR_W-1:0] kchar);
        res_t r;
        logic [WORD_W:0] sum;
        int n;
        r = '0;
        case (mode)
            OP_AND: begin mbuf = mdata; ac = ac & mbuf; end
            OP_TAD:
            begin
                mbuf = mdata;
                sum = {1'b0, ac} + {1'b0, mbuf};
                if (sum[WORD_W]) lnk = ~lnk;
                ac = sum[WORD_W-1:0];
            end
            OP_ISZ:
            begin
                mbuf = mdata + 1'b1;
                r.we = 1'b1; r.wd = mbuf;
                if (mbuf == '0) pc = pc + 1'b1;
            end
            OP_DCA: begin mbuf = ac; r.we = 1'b1; r.wd = mbuf; ac = '0; end
            OP_JMS: begin mbuf = pc; r.we = 1'b1; r.wd = mbuf; pc = addr + 1'b1; end
            OP_JMP: pc = addr;
            OP_KCF: r.ckf = 1'b1;
            OP_KSF: if (kflag) pc = pc + 1'b1;
            OP_KCC: begin ac = '0; r.ckf = 1'b1; end
            OP_KRS: ac = ac | {kchar, 4'b0};
            OP_KRB: begin ac = {kchar, 4'b0}; r.ckf = 1'b1; end
            OP_TFL: pflag = 1'b1;
            OP_TSF: if (pflag) pc = pc + 1'b1;
            OP_TCF: pflag = 1'b0;
            OP_TPC: begin r.pv = 1'b1; r.pchar = ac[11:4]; end
            OP_TLS: begin pflag = 1'b0; r.pv = 1'b1; r.pchar = ac[11:4]; end
            OP_CLA: ac = '0;
            OP_CLL: lnk = 1'b0;
            OP_CMA: ac = ~ac;
            OP_CML: lnk = ~lnk;
            OP_IAC: ac = ac + 1'b1;
            OP_RAR, OP_RTR:
            begin
                n = (mode == OP_RAR) ? 1 : 2;
                repeat (n) {ac, lnk} = {lnk, ac};
            end
            OP_RAL, OP_RTL:
            begin
                n = (mode == OP_RAL) ? 1 : 2;
                repeat (n) {lnk, ac} = {ac, lnk};
            end
            OP_SMA: r.skip = ac[11];
            OP_SZA: r.skip = (ac == '0);
            OP_SNL: r.skip = lnk;
            OP_SPA: r.skip = ~ac[11];
            OP_SNA: r.skip = (ac != '0);
            OP_SZL: r.skip = ~lnk;
            OP_SKP: pc = pc + 1'b1;
            OP_OSR: ac = ac | sw_reg;
            OP_HLT: r.hlt = 1'b1;
            default: ;
        endcase
        r.acc = ac;
        r.lnk = lnk;
        r.pc  = pc;
        return r;
    endfunction

    task automatic send(input row_t w);
        res_t r;
        if (!calm)
            while ($urandom_range(99) < 27)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, w.kchar, w.kflag, w.mdata, w.addr, w.mode};
        do @(posedge clk); while (!s_axis_tready);
        r = execute(w.mode, w.addr, w.mdata, w.kflag, w.kchar);
        pending_words.push_back(w.known ? w.want : r);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_regs(input logic [WORD_W-1:0] sw, input logic [WORD_W-1:0] sa);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= CFG_SWITCH; cfg_data <= sw;
        @(posedge clk);
        cfg_index <= CFG_START; cfg_data <= sa;
        @(posedge clk);
        cfg_we <= 1'b0;
        sw_reg = sw;
        // start address only matters at reset, which happens once
    endtask

    function automatic row_t rand_word();
        row_t w;
        w.mode  = ($urandom_range(99) < 90) ? MODE_W'($urandom_range(33))
                                            : MODE_W'($urandom_range(63, 34));
        w.addr  = WORD_W'($urandom);
        w.mdata = ($urandom_range(9) == 0) ? '1 : WORD_W'($urandom);
        w.kflag = 1'($urandom_range(1));
        w.kchar = CHAR_W'($urandom);
        w.known = 1'b0;
        w.want  = '0;
        return w;
    endfunction

    function automatic void add(input logic [MODE_W-1:0] m, input logic [WORD_W-1:0] a,
                                input logic [WORD_W-1:0] d, input logic kf,
                                input logic [CHAR_W-1:0] kc, input bit known, input res_t r);
        row_t w;
        w.mode = m; w.addr = a; w.mdata = d; w.kflag = kf; w.kchar = kc;
        w.known = known; w.want = r;
        plan.push_back(w);
    endfunction

    task automatic random_run(input int count, input int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at) drain();
            send(rand_word());
        end
    endtask

    // result side
    always @(posedge clk)
    begin
        res_t e;
        res_t a;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a.acc = m_axis_tdata[11:0];  a.lnk = m_axis_tdata[12];
            a.pc  = m_axis_tdata[24:13]; a.we  = m_axis_tdata[25];
            a.wd  = m_axis_tdata[37:26]; a.pv  = m_axis_tdata[38];
            a.pchar = m_axis_tdata[46:39]; a.ckf = m_axis_tdata[47];
            a.skip = m_axis_tdata[48];   a.hlt = m_axis_tdata[49];
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                e = pending_words.pop_front();
                if (e.acc != a.acc) $display("%0t: acc exp %h got %h", $time, e.acc, a.acc);
                if (e.lnk != a.lnk) $display("%0t: link exp %b got %b", $time, e.lnk, a.lnk);
                if (e.pc != a.pc) $display("%0t: pc exp %h got %h", $time, e.pc, a.pc);
                if (e.we != a.we) $display("%0t: we exp %b got %b", $time, e.we, a.we);
                if (e.wd != a.wd) $display("%0t: wdata exp %h got %h", $time, e.wd, a.wd);
                if (e.pv != a.pv) $display("%0t: pvalid exp %b got %b", $time, e.pv, a.pv);
                if (e.pchar != a.pchar)
                    $display("%0t: pchar exp %h got %h", $time, e.pchar, a.pchar);
                if (e.ckf != a.ckf) $display("%0t: kclr exp %b got %b", $time, e.ckf, a.ckf);
                if (e.skip != a.skip) $display("%0t: skip exp %b got %b", $time, e.skip, a.skip);
                if (e.hlt != a.hlt) $display("%0t: halt exp %b got %b", $time, e.hlt, a.hlt);
                if (e != a) errors++;
            end
        end
        if (hold_req)
        begin
            hold_left = HOLD_LEN;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0; cfg_index = CFG_SWITCH; cfg_data = '0;
        errors = 0; idle_cycles = 0; calm = 1'b0; hold_req = 1'b0; hold_left = 0;
        ac = '0; lnk = 1'b0; pc = 12'd128; mbuf = '0; pflag = 1'b0; sw_reg = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // typed rows: reset state, switch extreme, wrap of IAC and ISZ, halt
        add(OP_CLA, 12'h000, 12'h000, 1'b0, 8'h00, 1, '{12'h000, 1'b0, 12'h080, 1'b0,
            12'h000, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0});
        add(OP_OSR, 12'hFFF, 12'hFFF, 1'b1, 8'hFF, 1, '{12'hFFF, 1'b0, 12'h080, 1'b0,
            12'h000, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0});
        add(OP_IAC, 12'h000, 12'h000, 1'b0, 8'h00, 1, '{12'h000, 1'b0, 12'h080, 1'b0,
            12'h000, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0});
        add(OP_ISZ, 12'h000, 12'hFFF, 1'b0, 8'h00, 1, '{12'h000, 1'b0, 12'h081, 1'b1,
            12'h000, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0});
        add(OP_HLT, 12'hFFF, 12'h000, 1'b1, 8'h00, 1, '{12'h000, 1'b0, 12'h081, 1'b0,
            12'h000, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1});
        add(OP_CMA, 0, 0, 0, 0, 0, '0);
        add(OP_TAD, 12'hABC, 12'h001, 0, 0, 0, '0);    // carry out flips link
        add(OP_TAD, 12'h000, 12'hFFF, 0, 0, 0, '0);
        add(OP_AND, 12'h123, 12'hF0F, 0, 0, 0, '0);
        add(OP_DCA, 12'hFFF, 12'h000, 0, 0, 0, '0);
        add(OP_JMS, 12'hFFF, 12'h000, 0, 0, 0, '0);    // jump target addr + 1 wraps
        add(OP_JMP, 12'hFFF, 12'h000, 0, 0, 0, '0);
        add(OP_SKP, 0, 0, 0, 0, 0, '0);                // pc wraps to zero
        add(OP_KSF, 0, 0, 1'b1, 8'h00, 0, '0);
        add(OP_KSF, 0, 0, 1'b0, 8'hFF, 0, '0);
        add(OP_KRS, 0, 0, 1'b1, 8'hA5, 0, '0);
        add(OP_KRB, 0, 0, 1'b1, 8'hFF, 0, '0);
        add(OP_KCF, 0, 0, 1'b1, 8'h00, 0, '0);
        add(OP_TPC, 0, 0, 0, 0, 0, '0);
        add(OP_TSF, 0, 0, 0, 0, 0, '0);
        add(OP_TFL, 0, 0, 0, 0, 0, '0);
        add(OP_TSF, 0, 0, 0, 0, 0, '0);
        add(OP_TLS, 0, 0, 0, 0, 0, '0);
        add(OP_TSF, 0, 0, 0, 0, 0, '0);
        add(OP_TFL, 0, 0, 0, 0, 0, '0);
        add(OP_TCF, 0, 0, 0, 0, 0, '0);
        add(OP_TSF, 0, 0, 0, 0, 0, '0);
        add(OP_SMA, 0, 0, 0, 0, 0, '0);
        add(OP_SPA, 0, 0, 0, 0, 0, '0);
        add(OP_SZA, 0, 0, 0, 0, 0, '0);
        add(OP_SNA, 0, 0, 0, 0, 0, '0);
        add(OP_SNL, 0, 0, 0, 0, 0, '0);
        add(OP_SZL, 0, 0, 0, 0, 0, '0);
        add(OP_CML, 0, 0, 0, 0, 0, '0);
        add(OP_RAR, 0, 0, 0, 0, 0, '0);
        add(OP_RTR, 0, 0, 0, 0, 0, '0);
        add(OP_RAL, 0, 0, 0, 0, 0, '0);
        add(OP_RTL, 0, 0, 0, 0, 0, '0);
        add(OP_CLL, 0, 0, 0, 0, 0, '0);
        add(OP_KCC, 0, 0, 0, 0, 0, '0);
        add(6'd34, 12'hFFF, 12'hFFF, 1'b1, 8'hFF, 0, '0);  // unused modes do nothing
        add(OP_NOP, 12'hFFF, 12'hFFF, 1'b1, 8'hFF, 0, '0);

        set_regs(12'hFFF, 12'h000);
        foreach (plan[i]) send(plan[i]);
        drain();

        set_regs(12'h000, 12'hFFF);
        random_run(400, 200);    // sender stops until the queue has emptied
        drain();

        set_regs(WORD_W'($urandom), WORD_W'($urandom));
        calm = 1'b1;             // no gaps on either side for this stretch
        random_run(400, -1);
        drain();
        calm = 1'b0;

        set_regs(12'h555, 12'hAAA);
        hold_req = 1'b1;         // receiver stalls while the input backs up
        random_run(400, -1);
        drain();

        set_regs(WORD_W'($urandom), 12'h080);
        random_run(400, -1);
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- accumulator_machine_execute_unit.f -----
rtl/core/amx_pkg.sv
rtl/core/amx_front.sv
rtl/core/amx_queue.sv
rtl/core/amx_back.sv
rtl/core/accumulator_machine_execute_unit.sv
verif/tb.sv
